// ===== hdl/steering_torque_pid_assert.svh =====
// ----------------------------------------------------------------------------
// steering_torque_pid_assert: assertion macros
// Concurrent assertion wrappers on clock; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef STEERING_TORQUE_PID_ASSERT_SVH
`define STEERING_TORQUE_PID_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define STP_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// checked on every edge, reset included
`define STP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define STP_ASSERT_CLK(label, prop, msg)
`define STP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hdl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg: steering torque pid shared definitions
// Field widths, thresholds, path codes and the types passed between stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package stp_pkg;

   // default tuning
   localparam int SMALL_ERROR_DEF  = 100;
   localparam int ANGLE_OFFSET_DEF = 0;

   // field widths
   localparam int ANGLE_W    = 20;
   localparam int SPEED_W    = 12;
   localparam int GAIN_W     = 16;
   localparam int ILIM_W     = 23;
   localparam int TLIM_W     = 15;
   localparam int ERR_W      = 22;
   localparam int SUM_W      = 24;
   localparam int DERIV_W    = 23;
   localparam int TORQUE_W   = 16;
   localparam int PATH_W     = 3;
   localparam int PROD_W     = 42;
   localparam int FRAC_W     = 12;
   localparam int RAW_W      = PROD_W - FRAC_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;

   // thresholds in field units
   localparam int STOP_SPEED  = 30;
   localparam int LAZY_SPEED  = 100;
   localparam int LAZY_ERROR  = 30;
   localparam int LAZY_CMD    = 300;
   localparam int LAZY_TORQUE = 160;

   typedef enum logic [PATH_W-1:0] {
      PATH_DISABLED = 3'd0,
      PATH_STOPPED  = 3'd1,
      PATH_LAZY     = 3'd2,
      PATH_STRICT   = 3'd3,
      PATH_NORMAL   = 3'd4
   } path_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P        = 3'd0,
      CSR_GAIN_I        = 3'd1,
      CSR_GAIN_D        = 3'd2,
      CSR_STRICT_GAIN_P = 3'd3,
      CSR_STRICT_GAIN_I = 3'd4,
      CSR_STRICT_GAIN_D = 3'd5,
      CSR_INTEGRAL_LIM  = 3'd6,
      CSR_TORQUE_LIM    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [GAIN_W-1:0] strict_gain_p;
      logic [GAIN_W-1:0] strict_gain_i;
      logic [GAIN_W-1:0] strict_gain_d;
      logic [ILIM_W-1:0] integral_limit;
      logic [TLIM_W-1:0] torque_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] measured_angle;
      logic signed [ANGLE_W-1:0] commanded_angle;
      logic [SPEED_W-1:0]        speed;
      logic                      program_mode;
   } sample_type;

   typedef struct packed {
      path_type                  path;
      logic                      lazy_pos;
      logic signed [ERR_W-1:0]   err;
      logic signed [SUM_W-1:0]   sum;
      logic signed [DERIV_W-1:0] deriv;
      logic [GAIN_W-1:0]         kp;
      logic [GAIN_W-1:0]         ki;
      logic [GAIN_W-1:0]         kd;
   } work_type;

endpackage

// ===== hdl/stp_csr.sv =====
// ----------------------------------------------------------------------------
// stp_csr: configuration registers
// Gains and limits, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stp_csr import stp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:        cfg_in.gain_p         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:        cfg_in.gain_i         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:        cfg_in.gain_d         = csr_wdata[GAIN_W-1:0];
            CSR_STRICT_GAIN_P: cfg_in.strict_gain_p  = csr_wdata[GAIN_W-1:0];
            CSR_STRICT_GAIN_I: cfg_in.strict_gain_i  = csr_wdata[GAIN_W-1:0];
            CSR_STRICT_GAIN_D: cfg_in.strict_gain_d  = csr_wdata[GAIN_W-1:0];
            CSR_INTEGRAL_LIM:  cfg_in.integral_limit = csr_wdata[ILIM_W-1:0];
            CSR_TORQUE_LIM:    cfg_in.torque_limit   = csr_wdata[TLIM_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/stp_front.sv =====
// ----------------------------------------------------------------------------
// stp_front: request register, error and integral state
// Registers the request, forms the error, updates the clamped integral and
// the previous error, and picks the path and gain set for the product stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "steering_torque_pid_assert.svh"
module stp_front import stp_pkg::*; #(
   parameter int SMALL_ERROR  = SMALL_ERROR_DEF,
   parameter int ANGLE_OFFSET = ANGLE_OFFSET_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  work_valid,
   input  logic                  work_ready,
   output work_type              work
);

   localparam logic signed [ERR_W-1:0] OFFSET_C    = ERR_W'(ANGLE_OFFSET);
   localparam logic signed [ERR_W-1:0] SMALL_C     = ERR_W'(SMALL_ERROR);
   localparam logic signed [ERR_W-1:0] LAZY_ERR_C  = ERR_W'(LAZY_ERROR);
   localparam logic signed [ANGLE_W-1:0] LAZY_CMD_C = ANGLE_W'(LAZY_CMD);
   localparam logic [SPEED_W-1:0] STOP_SPEED_C     = SPEED_W'(STOP_SPEED);
   localparam logic [SPEED_W-1:0] LAZY_SPEED_C     = SPEED_W'(LAZY_SPEED);

   sample_type s0_ff, s0_in;
   logic       s0_valid_ff, s0_valid_in;
   work_type   s1_ff, s1_in;
   logic       s1_valid_ff, s1_valid_in;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [ERR_W-1:0] last_err_ff, last_err_in;
   logic                    last_valid_ff, last_valid_in;

   logic                      s1_ready;
   logic                      adv;
   logic                      slow;
   logic signed [ERR_W-1:0]   err;
   logic signed [SUM_W:0]     sum_raw;
   logic signed [SUM_W:0]     lim_pos;
   logic signed [SUM_W:0]     lim_neg;
   logic signed [SUM_W-1:0]   sum_clamp;
   logic signed [DERIV_W-1:0] deriv;
   logic                      small_err;
   logic                      lazy;

   // pipeline flow
   assign s1_ready   = !s1_valid_ff || work_ready;
   assign adv        = s0_valid_ff && s1_ready;
   assign req_tready = !s0_valid_ff || s1_ready;

   // request register
   always_comb begin
      s0_in       = s0_ff;
      s0_valid_in = s0_valid_ff;
      if (req_tready) begin
         s0_valid_in = req_tvalid;
         s0_in.measured_angle  = req_tdata[ANGLE_W-1:0];
         s0_in.commanded_angle = req_tdata[2*ANGLE_W-1:ANGLE_W];
         s0_in.speed           = req_tdata[2*ANGLE_W+SPEED_W-1:2*ANGLE_W];
         s0_in.program_mode    = req_tdata[2*ANGLE_W+SPEED_W];
      end
   end

   // error, clamped integral and derivative
   always_comb begin
      slow    = s0_ff.speed < STOP_SPEED_C;
      err     = ERR_W'(s0_ff.commanded_angle) - ERR_W'(s0_ff.measured_angle) + OFFSET_C;
      sum_raw = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(err);
      lim_pos = (SUM_W+1)'({1'b0, cfg.integral_limit});
      lim_neg = -lim_pos;
      if (sum_raw > lim_pos) begin
         sum_clamp = SUM_W'(lim_pos);
      end else if (sum_raw < lim_neg) begin
         sum_clamp = SUM_W'(lim_neg);
      end else begin
         sum_clamp = SUM_W'(sum_raw);
      end
      deriv     = last_valid_ff ? (DERIV_W'(err) - DERIV_W'(last_err_ff)) : '0;
      small_err = (err < SMALL_C) && (err > -SMALL_C);
      lazy      = (err < LAZY_ERR_C) && (err > -LAZY_ERR_C)
               && (s0_ff.commanded_angle < LAZY_CMD_C)
               && (s0_ff.commanded_angle > -LAZY_CMD_C)
               && (s0_ff.speed < LAZY_SPEED_C);
   end

   // path, gain selection and state update
   always_comb begin
      s1_in         = s1_ff;
      s1_valid_in   = s1_valid_ff;
      sum_in        = sum_ff;
      last_err_in   = last_err_ff;
      last_valid_in = last_valid_ff;
      if (s1_ready) begin
         s1_valid_in = s0_valid_ff;
      end
      if (adv) begin
         s1_in.err      = err;
         s1_in.deriv    = deriv;
         // strictly positive error: sign bit clear and not zero
         s1_in.lazy_pos = !err[ERR_W-1] && (err != '0);
         s1_in.kp       = small_err ? cfg.strict_gain_p : cfg.gain_p;
         s1_in.ki       = small_err ? cfg.strict_gain_i : cfg.gain_i;
         s1_in.kd       = small_err ? cfg.strict_gain_d : cfg.gain_d;
         s1_in.sum      = sum_clamp;
         if (!s0_ff.program_mode) begin
            s1_in.path = PATH_DISABLED;
            sum_in     = '0;
         end else if (slow) begin
            s1_in.path = PATH_STOPPED;
         end else begin
            if (lazy) begin
               s1_in.path = PATH_LAZY;
               sum_in     = '0;
            end else begin
               s1_in.path = small_err ? PATH_STRICT : PATH_NORMAL;
               sum_in     = sum_clamp;
            end
            last_err_in   = err;
            last_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         sum_ff        <= '0;
         last_err_ff   <= '0;
         last_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff   <= s0_valid_in;
         s1_valid_ff   <= s1_valid_in;
         sum_ff        <= sum_in;
         last_err_ff   <= last_err_in;
         last_valid_ff <= last_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      s1_ff <= s1_in;
   end

   assign work_valid = s1_valid_ff;
   assign work       = s1_ff;

   // manual mode empties the integral
   `STP_ASSERT_CLK(a_manual_clears_sum, (adv && !s0_ff.program_mode) |=> (sum_ff == '0), "manual request left integral set")
   // a stopped vehicle leaves the controller state alone
   `STP_ASSERT_CLK(a_stopped_holds, (adv && s0_ff.program_mode && slow) |=> ($stable(sum_ff) && $stable(last_err_ff) && $stable(last_valid_ff)), "stopped request changed state")
   // the lazy case drops the integral
   `STP_ASSERT_CLK(a_lazy_clears_sum, (adv && s0_ff.program_mode && !slow && lazy) |=> (sum_ff == '0), "lazy request left integral set")

endmodule

// ===== hdl/stp_back.sv =====
// ----------------------------------------------------------------------------
// stp_back: gain products, torque clip and response register
// Multiplies error, integral and derivative by the chosen gains, scales,
// clips to the torque limit and holds the response until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "steering_torque_pid_assert.svh"
module stp_back import stp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  work_valid,
   output logic                  work_ready,
   input  work_type              work,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic signed [RAW_W-1:0] LAZY_C = RAW_W'(LAZY_TORQUE);

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [TORQUE_W-1:0] torque_ff, torque_in;
   path_type                   path_ff, path_in;
   logic                       clipped_ff, clipped_in;

   logic signed [GAIN_W:0]   kp_s, ki_s, kd_s;
   logic signed [PROD_W-1:0] prod_p, prod_i, prod_d, total;
   logic signed [RAW_W-1:0]  raw;
   logic signed [RAW_W-1:0]  lim_pos, lim_neg;

   assign work_ready = !rsp_valid_ff || rsp_tready;

   // weighted sum, floor-scaled by 4096
   always_comb begin
      kp_s   = {1'b0, work.kp};
      ki_s   = {1'b0, work.ki};
      kd_s   = {1'b0, work.kd};
      prod_p = PROD_W'(work.err) * PROD_W'(kp_s);
      prod_i = PROD_W'(work.sum) * PROD_W'(ki_s);
      prod_d = PROD_W'(work.deriv) * PROD_W'(kd_s);
      total  = prod_p + prod_i + prod_d;
      if (work.path == PATH_LAZY) begin
         raw = work.lazy_pos ? LAZY_C : -LAZY_C;
      end else begin
         raw = RAW_W'(total >>> FRAC_W);
      end
      lim_pos = RAW_W'({1'b0, cfg.torque_limit});
      lim_neg = -lim_pos;
   end

   // clip and response register load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      torque_in    = torque_ff;
      path_in      = path_ff;
      clipped_in   = clipped_ff;
      if (work_ready) begin
         rsp_valid_in = work_valid;
         path_in      = work.path;
         case (work.path)
            PATH_DISABLED, PATH_STOPPED: begin
               torque_in  = '0;
               clipped_in = 1'b0;
            end
            default: begin
               if (raw > lim_pos) begin
                  torque_in  = TORQUE_W'(lim_pos);
                  clipped_in = 1'b1;
               end else if (raw < lim_neg) begin
                  torque_in  = TORQUE_W'(lim_neg);
                  clipped_in = 1'b1;
               end else begin
                  torque_in  = TORQUE_W'(raw);
                  clipped_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      torque_ff  <= torque_in;
      path_ff    <= path_in;
      clipped_ff <= clipped_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-TORQUE_W-PATH_W-1){1'b0}}, clipped_ff, path_ff, torque_ff};

   // a clipped torque sits exactly on the limit
   `STP_ASSERT_CLK(a_clip_on_limit, (rsp_valid_ff && clipped_ff) |-> ((torque_ff == TORQUE_W'({1'b0, cfg.torque_limit})) || (torque_ff == -TORQUE_W'({1'b0, cfg.torque_limit}))), "clipped torque off the limit")
   // disabled and stopped give no torque
   `STP_ASSERT_CLK(a_idle_paths_zero, (rsp_valid_ff && ((path_ff == PATH_DISABLED) || (path_ff == PATH_STOPPED))) |-> ((torque_ff == '0) && !clipped_ff), "torque on an idle path")
   // reset drops any pending response
   `STP_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid_ff, "response valid after reset")

endmodule

// ===== hdl/steering_torque_pid.sv =====
// A request passes the request register, the work register and the response register.
// Throughput: one request per cycle while responses are taken; three gain products feed one adder and clip.
// The integral and previous error update at most once per request, in the front stage.
// Reset (synchronous) clears the state, the gains and limits and all valid bits.
// There is no clearing pass; the block takes requests right after reset.
// ----------------------------------------------------------------------------
// steering_torque_pid: steering torque pid controller with anti-windup clamp
// Error, clamped integral and derivative, gain products, torque clip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module steering_torque_pid import stp_pkg::*; #(
   parameter int SMALL_ERROR  = SMALL_ERROR_DEF,
   parameter int ANGLE_OFFSET = ANGLE_OFFSET_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // measured_angle, commanded_angle, speed, program_mode, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // torque, path_taken, clipped, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cfg_type  cfg;
   work_type work;
   logic     work_valid;
   logic     work_ready;

   // configuration registers
   stp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // error and integral stage
   stp_front #(
      .SMALL_ERROR  (SMALL_ERROR),
      .ANGLE_OFFSET (ANGLE_OFFSET)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .work_valid (work_valid),
      .work_ready (work_ready),
      .work       (work)
   );

   // product and clip stage
   stp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .work_valid (work_valid),
      .work_ready (work_ready),
      .work       (work),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: steering_torque_pid self-checking testbench
// Sends control samples over the request stream with random gaps and
// back-pressure. A local PID model predicts each response that the plan does not fix, and the
// torque, path and clip flag of every response are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench import stp_pkg::*; ();

   typedef struct packed {
      logic signed [TORQUE_W-1:0] torque;
      path_type                   path;
      logic                       clipped;
   } torque_result_type;

   typedef struct packed {
      sample_type        smp;
      bit                typed;
      torque_result_type want;
   } plan_row_type;

   localparam int PHASE_COUNT      = 8;
   localparam int ITEMS_PER_PHASE  = 154;
   localparam int DRAIN_CYCLES     = 4;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // measured_angle, commanded_angle, speed, program_mode, zero fill
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // torque, path_taken, clipped, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predictor copy of the registers and the controller state
   cfg_type gains;
   longint  integral_sum;
   longint  prev_error;
   bit      prev_error_valid;

   torque_result_type pending_torques[$];
   plan_row_type      directed_plan[$];
   torque_result_type observed_want;
   int                mismatch_count;
   int                send_idle_pct;
   int                recv_stall_pct;

   steering_torque_pid uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint magnitude(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   // one control step: updates the integral and previous error, returns torque
   function automatic torque_result_type compute_torque(input sample_type smp);
      torque_result_type r;
      longint meas, cmd, err, lim, deriv, kp, ki, kd, trq, tlim;
      meas = longint'($signed(smp.measured_angle));
      cmd  = longint'($signed(smp.commanded_angle));
      trq  = 0;
      r.clipped = 1'b0;
      if (!smp.program_mode) begin
         integral_sum = 0;
         r.path = PATH_DISABLED;
      end else if (smp.speed < STOP_SPEED) begin
         r.path = PATH_STOPPED;
      end else begin
         err   = cmd - (meas - longint'(ANGLE_OFFSET_DEF));
         lim   = longint'(gains.integral_limit);
         deriv = prev_error_valid ? err - prev_error : 0;
         kp    = longint'(gains.gain_p);
         ki    = longint'(gains.gain_i);
         kd    = longint'(gains.gain_d);
         // anti-windup clamp
         integral_sum = integral_sum + err;
         if (integral_sum > lim) integral_sum = lim;
         if (integral_sum < -lim) integral_sum = -lim;
         r.path = PATH_NORMAL;
         if (magnitude(err) < SMALL_ERROR_DEF) begin
            kp = longint'(gains.strict_gain_p);
            ki = longint'(gains.strict_gain_i);
            kd = longint'(gains.strict_gain_d);
            r.path = PATH_STRICT;
         end
         // slow and nearly straight: fixed torque, integral dropped
         if (magnitude(err) < LAZY_ERROR && magnitude(cmd) < LAZY_CMD &&
             smp.speed < LAZY_SPEED) begin
            integral_sum = 0;
            trq = (err > 0) ? longint'(LAZY_TORQUE) : -longint'(LAZY_TORQUE);
            r.path = PATH_LAZY;
         end else begin
            trq = (err * kp + integral_sum * ki + deriv * kd) >>> FRAC_W;
         end
         tlim = longint'(gains.torque_limit);
         if (trq > tlim) begin
            trq = tlim;
            r.clipped = 1'b1;
         end
         if (trq < -tlim) begin
            trq = -tlim;
            r.clipped = 1'b1;
         end
         prev_error       = err;
         prev_error_valid = 1'b1;
      end
      r.torque = trq[TORQUE_W-1:0];
      return r;
   endfunction

   function automatic void add_row(input int meas, input int cmd, input int spd,
                                   input bit mode, input bit typed, input int trq,
                                   input path_type p, input bit clp);
      plan_row_type row;
      row.smp.measured_angle  = meas[ANGLE_W-1:0];
      row.smp.commanded_angle = cmd[ANGLE_W-1:0];
      row.smp.speed           = spd[SPEED_W-1:0];
      row.smp.program_mode    = mode;
      row.typed               = typed;
      row.want.torque         = trq[TORQUE_W-1:0];
      row.want.path           = p;
      row.want.clipped        = clp;
      directed_plan.push_back(row);
   endfunction

   function automatic int extreme_angle();
      case ($urandom_range(0, 3))
         0: return -524288;
         1: return 524287;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   // mostly program mode at driving speed, weighted toward the thresholds
   function automatic sample_type make_sample();
      sample_type s;
      int meas, cmd, err, spd, kind;
      bit mode;
      kind = $urandom_range(0, 19);
      mode = 1'b1;
      spd  = $urandom_range(STOP_SPEED, 4095);
      cmd  = $urandom;
      meas = $urandom;
      case (kind)
         0: mode = 1'b0;
         1: spd = $urandom_range(0, STOP_SPEED - 1);
         2, 3, 4, 5: begin
            // around the lazy window
            cmd  = int'($urandom_range(0, 640)) - 320;
            err  = int'($urandom_range(0, 80)) - 40;
            meas = cmd - err;
            spd  = $urandom_range(STOP_SPEED, 120);
         end
         6, 7, 8, 9: begin
            // around the strict gain threshold
            cmd  = int'($urandom_range(0, 40000)) - 20000;
            err  = int'($urandom_range(0, 240)) - 120;
            meas = cmd - err;
         end
         10, 11, 12: begin
            cmd  = int'($urandom_range(0, 200000)) - 100000;
            err  = int'($urandom_range(0, 20000)) - 10000;
            meas = cmd - err;
         end
         13: begin
            cmd  = extreme_angle();
            meas = extreme_angle();
         end
         default: ;
      endcase
      s.measured_angle  = meas[ANGLE_W-1:0];
      s.commanded_angle = cmd[ANGLE_W-1:0];
      s.speed           = spd[SPEED_W-1:0];
      s.program_mode    = mode;
      return s;
   endfunction

   function automatic cfg_type make_settings(input int phase);
      cfg_type c;
      c.gain_p         = GAIN_W'($urandom);
      c.gain_i         = GAIN_W'($urandom);
      c.gain_d         = GAIN_W'($urandom);
      c.strict_gain_p  = GAIN_W'($urandom);
      c.strict_gain_i  = GAIN_W'($urandom);
      c.strict_gain_d  = GAIN_W'($urandom);
      c.integral_limit = ILIM_W'($urandom);
      c.torque_limit   = TLIM_W'($urandom);
      case (phase)
         0: begin
            c.gain_p         = c.gain_p & 16'h1fff;
            c.gain_i         = c.gain_i & 16'h00ff;
            c.gain_d         = c.gain_d & 16'h1fff;
            c.strict_gain_p  = c.strict_gain_p & 16'h3fff;
            c.strict_gain_i  = c.strict_gain_i & 16'h00ff;
            c.strict_gain_d  = c.strict_gain_d & 16'h3fff;
            c.integral_limit = ILIM_W'($urandom_range(0, 200000));
         end
         1: c = '1;
         2: c = '0;
         4: c.torque_limit = '0;
         5: c.torque_limit = TLIM_W'($urandom_range(0, 200));
         6: begin
            c.gain_p         = '1;
            c.gain_i         = '1;
            c.gain_d         = '1;
            c.strict_gain_p  = '1;
            c.strict_gain_i  = '1;
            c.strict_gain_d  = '1;
            c.integral_limit = '0;
         end
         default: ;
      endcase
      return c;
   endfunction

   // bits above the register width are random and must be ignored
   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value, input int width);
      logic [CSR_DATA_W-1:0] noise;
      noise = CSR_DATA_W'($urandom);
      noise = noise << width;
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value | noise;
      @(negedge clock);
   endtask

   task automatic load_settings(input cfg_type c);
      write_register(CSR_GAIN_P, c.gain_p, GAIN_W);
      write_register(CSR_GAIN_I, c.gain_i, GAIN_W);
      write_register(CSR_GAIN_D, c.gain_d, GAIN_W);
      write_register(CSR_STRICT_GAIN_P, c.strict_gain_p, GAIN_W);
      write_register(CSR_STRICT_GAIN_I, c.strict_gain_i, GAIN_W);
      write_register(CSR_STRICT_GAIN_D, c.strict_gain_d, GAIN_W);
      write_register(CSR_INTEGRAL_LIM, c.integral_limit, ILIM_W);
      write_register(CSR_TORQUE_LIM, c.torque_limit, TLIM_W);
      csr_wr_en <= 1'b0;
      gains = c;
   endtask

   // called and returns at a falling edge; predicts at acceptance
   task automatic send_sample(input sample_type smp, input bit typed,
                              input torque_result_type typed_want);
      torque_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, smp.program_mode, smp.speed,
                     smp.commanded_angle, smp.measured_angle};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = compute_torque(smp);
      pending_torques.push_back(typed ? typed_want : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_torques.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_torques.size() == 0) begin
            $error("response with no request pending: data %h", rsp_tdata);
            mismatch_count++;
         end else begin
            observed_want = pending_torques.pop_front();
            if (rsp_tdata[15:0] !== observed_want.torque) begin
               $error("torque: expected %0d, got %0d", observed_want.torque,
                      $signed(rsp_tdata[15:0]));
               mismatch_count++;
            end
            if (rsp_tdata[18:16] !== observed_want.path) begin
               $error("path_taken: expected %0d, got %0d", observed_want.path,
                      rsp_tdata[18:16]);
               mismatch_count++;
            end
            if (rsp_tdata[19] !== observed_want.clipped) begin
               $error("clipped: expected %0d, got %0d", observed_want.clipped,
                      rsp_tdata[19]);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #4000000;
      $display("steering_torque_pid: mismatch");
      $finish;
   end

   initial begin
      cfg_type directed_cfg;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      rsp_tready       = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      mismatch_count   = 0;
      gains            = '0;
      integral_sum     = 0;
      prev_error       = 0;
      prev_error_valid = 1'b0;

      // directed plan: manual, stopped, lazy window, strict edges, saturation
      add_row(-524288, 524287, 4095, 1'b0, 1'b1, 0, PATH_DISABLED, 1'b0);
      add_row(524287, -524288, 0, 1'b1, 1'b1, 0, PATH_STOPPED, 1'b0);
      add_row(0, 0, 29, 1'b1, 1'b1, 0, PATH_STOPPED, 1'b0);
      add_row(0, 1000, 30, 1'b1, 1'b0, 0, PATH_NORMAL, 1'b0);
      add_row(0, 1000, 30, 1'b1, 1'b0, 0, PATH_NORMAL, 1'b0);
      add_row(0, 29, 99, 1'b1, 1'b1, 160, PATH_LAZY, 1'b0);
      add_row(10, 10, 50, 1'b1, 1'b1, -160, PATH_LAZY, 1'b0);
      add_row(-270, -299, 99, 1'b1, 1'b1, -160, PATH_LAZY, 1'b0);
      add_row(0, 30, 50, 1'b1, 1'b0, 0, PATH_STRICT, 1'b0);
      add_row(300, 300, 50, 1'b1, 1'b0, 0, PATH_STRICT, 1'b0);
      add_row(5, 10, 100, 1'b1, 1'b0, 0, PATH_STRICT, 1'b0);
      add_row(1000, 1099, 500, 1'b1, 1'b0, 0, PATH_STRICT, 1'b0);
      add_row(1000, 1100, 500, 1'b1, 1'b0, 0, PATH_NORMAL, 1'b0);
      add_row(1099, 1000, 500, 1'b1, 1'b0, 0, PATH_STRICT, 1'b0);
      add_row(1100, 1000, 500, 1'b1, 1'b0, 0, PATH_NORMAL, 1'b0);
      add_row(-524288, 524287, 4095, 1'b1, 1'b1, 2000, PATH_NORMAL, 1'b1);
      add_row(524287, -524288, 4095, 1'b1, 1'b1, -2000, PATH_NORMAL, 1'b1);
      add_row(0, 50000, 200, 1'b1, 1'b0, 0, PATH_NORMAL, 1'b0);
      add_row(0, 50000, 200, 1'b1, 1'b0, 0, PATH_NORMAL, 1'b0);
      add_row(0, 50000, 200, 1'b1, 1'b0, 0, PATH_NORMAL, 1'b0);
      add_row(0, 0, 0, 1'b0, 1'b1, 0, PATH_DISABLED, 1'b0);
      add_row(0, 50000, 10, 1'b1, 1'b1, 0, PATH_STOPPED, 1'b0);
      add_row(0, 50000, 200, 1'b1, 1'b0, 0, PATH_NORMAL, 1'b0);
      add_row(-1, -1, 4095, 1'b1, 1'b0, 0, PATH_STRICT, 1'b0);

      // reset, released at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_cfg.gain_p         = 16'd4096;
      directed_cfg.gain_i         = 16'd64;
      directed_cfg.gain_d         = 16'd512;
      directed_cfg.strict_gain_p  = 16'd8192;
      directed_cfg.strict_gain_i  = 16'd128;
      directed_cfg.strict_gain_d  = 16'd1024;
      directed_cfg.integral_limit = 23'd100000;
      directed_cfg.torque_limit   = 15'd2000;
      load_settings(directed_cfg);
      foreach (directed_plan[i]) begin
         send_sample(directed_plan[i].smp, directed_plan[i].typed, directed_plan[i].want);
      end

      // random phases, each with its own register setting and one of four idling patterns
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         req_tvalid <= 1'b0;
         wait_drained();
         load_settings(make_settings(phase));
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 49;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 49;
            end
            default: begin
               send_idle_pct  = 27;
               recv_stall_pct = 27;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_sample(make_sample(), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      if (mismatch_count == 0) begin
         $display("steering_torque_pid: match");
      end else begin
         $display("steering_torque_pid: mismatch");
      end
      $finish;
   end

endmodule
